// ----- rtl/core/lts_pkg.sv -----
package lts_pkg;

   localparam int MAX_TOKEN_LEN  = 8;
   localparam int RESERVED_WORDS = 8;
   localparam int NUM_WORD_REGS  = 8;
   localparam int WORD_W         = 64;
   localparam int WORD_SEL_W     = $clog2(NUM_WORD_REGS);
   localparam int CSR_INDEX_W    = 4;
   localparam int KIND_W         = 4;
   localparam int IDX_W          = 3;
   localparam int LEN_W          = 4;
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W     = $clog2(FIFO_DEPTH + 1);

   localparam logic [KIND_W-1:0] K_END      = 4'd0;
   localparam logic [KIND_W-1:0] K_ERROR    = 4'd1;
   localparam logic [KIND_W-1:0] K_IDENT    = 4'd2;
   localparam logic [KIND_W-1:0] K_NUMBER   = 4'd3;
   localparam logic [KIND_W-1:0] K_ASSIGN   = 4'd4;
   localparam logic [KIND_W-1:0] K_EQ       = 4'd5;
   localparam logic [KIND_W-1:0] K_LT       = 4'd6;
   localparam logic [KIND_W-1:0] K_PLUS     = 4'd7;
   localparam logic [KIND_W-1:0] K_MINUS    = 4'd8;
   localparam logic [KIND_W-1:0] K_TIMES    = 4'd9;
   localparam logic [KIND_W-1:0] K_OVER     = 4'd10;
   localparam logic [KIND_W-1:0] K_LPAREN   = 4'd11;
   localparam logic [KIND_W-1:0] K_RPAREN   = 4'd12;
   localparam logic [KIND_W-1:0] K_SEMI     = 4'd13;
   localparam logic [KIND_W-1:0] K_RESERVED = 4'd14;

   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_TIMES  = 8'h2A;
   localparam logic [7:0] CH_OVER   = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;

   typedef enum logic [2:0] {
      ST_START,
      ST_ASSIGN,
      ST_COMMENT,
      ST_NUM,
      ST_ID
   } scan_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  index;
      logic [LEN_W-1:0]  length;
      logic [WORD_W-1:0] bytes;
      logic              last;
   } token_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NL};
   endfunction

   function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         CH_EQ:     k = K_EQ;
         CH_LT:     k = K_LT;
         CH_PLUS:   k = K_PLUS;
         CH_MINUS:  k = K_MINUS;
         CH_TIMES:  k = K_TIMES;
         CH_OVER:   k = K_OVER;
         CH_LPAREN: k = K_LPAREN;
         CH_RPAREN: k = K_RPAREN;
         CH_SEMI:   k = K_SEMI;
         default:   k = K_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/core/lts_req_if.sv -----
interface lts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_input;

   modport source (output valid, source_byte, end_of_input, input ready);
   modport sink (input valid, source_byte, end_of_input, output ready);
endinterface

// ----- rtl/core/lts_rsp_if.sv -----
interface lts_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [2:0]  reserved_index;
   logic [3:0]  lexeme_length;
   logic [63:0] lexeme_bytes;
   logic        last_of_item;

   modport source (output valid, token_kind, reserved_index, lexeme_length, lexeme_bytes,
                   last_of_item, input ready);
   modport sink (input valid, token_kind, reserved_index, lexeme_length, lexeme_bytes,
                 last_of_item, output ready);
endinterface

// ----- rtl/core/lexical_token_scanner_top.sv -----
// Byte-at-a-time lexical scanner for a small language.
// req_ch carries one source byte or an end-of-input mark per item; rsp_ch
// carries finished tokens (kind, reserved slot, lexeme length and bytes) and
// flags the last token that each request item caused. One item yields zero,
// one or two tokens.
// Items are accepted one per cycle while req_ch.ready is high; the scanner
// step and the eight reserved word compares run in the accept cycle and the
// tokens are written to a four-entry token queue. With the queue empty, the
// first token of an item appears on rsp_ch in the cycle after the item is
// accepted; the second token of a pair follows in the cycle after the first
// is taken. The queue drains one token per cycle while rsp_ch.ready is high,
// so items that give two tokens slow the sustained item rate.
// req_ch.ready is high while the queue has room for two tokens, so input keeps
// flowing while the receiver stalls until the queue fills; nothing is lost.
// csr_we writes reserved word csr_index (0 to 7) with csr_wdata; other
// indexes are ignored. Write only while the block is idle.
// Synchronous reset returns the scanner to its start state with an empty
// lexeme, clears all reserved words and empties the token queue.
module lexical_token_scanner_top
   import lts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lts_req_if.sink                req_ch,
   lts_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   logic                  accept;
   logic [1:0]            tok_count;
   token_type             tok0;
   token_type             tok1;
   token_type             head;
   logic                  head_valid;
   logic                  room;
   logic [FIFO_LVL_W-1:0] level;
   logic                  pop;

   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;
   assign pop          = head_valid && rsp_ch.ready;

   lts_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .source_byte  (req_ch.source_byte),
      .end_of_input (req_ch.end_of_input),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .tok_count    (tok_count),
      .tok0         (tok0),
      .tok1         (tok1)
   );

   lts_token_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (accept ? tok_count : 2'd0),
      .push0      (tok0),
      .push1      (tok1),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .room       (room),
      .level      (level)
   );

   assign rsp_ch.valid          = head_valid;
   assign rsp_ch.token_kind     = head.kind;
   assign rsp_ch.reserved_index = head.index;
   assign rsp_ch.lexeme_length  = head.length;
   assign rsp_ch.lexeme_bytes   = head.bytes;
   assign rsp_ch.last_of_item   = head.last;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= FIFO_LVL_W'(FIFO_DEPTH))
      else $error("token queue overfilled");

   a_two_tokens_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && tok_count == 2'd2) |=> level >= FIFO_LVL_W'(2))
      else $error("pair of tokens not both queued");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      (accept && tok_count == 2'd2) |-> (!tok0.last && tok1.last))
      else $error("last token flag misplaced");

   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      (pop && head.kind == K_END) |-> (head.length == '0 && head.bytes == '0))
      else $error("end token with lexeme");

endmodule

// ----- rtl/core/lts_scan.sv -----
module lts_scan
   import lts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             source_byte,
   input  logic                   end_of_input,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata,
   output logic [1:0]             tok_count,
   output token_type              tok0,
   output token_type              tok1
);

   logic [WORD_W-1:0] reserved_ff [NUM_WORD_REGS];
   scan_state_type    state_ff, state_in;
   logic [WORD_W-1:0] lex_ff, lex_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              over_ff, over_in;

   logic [WORD_W-1:0] sav_lex;
   logic [LEN_W-1:0]  sav_cnt;
   logic              sav_over;

   logic              match_any;
   logic [IDX_W-1:0]  match_idx;

   logic              st_valid;
   token_type         st_tok;
   scan_state_type    st_state;
   logic [WORD_W-1:0] st_lex;
   logic [LEN_W-1:0]  st_cnt;

   logic              pre_valid;
   token_type         pre_tok;
   logic              do_start;

   // append the byte to the lexeme, or mark overflow
   always_comb begin
      sav_lex  = lex_ff;
      sav_cnt  = cnt_ff;
      sav_over = over_ff;
      if (cnt_ff < LEN_W'(MAX_TOKEN_LEN)) begin
         for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
            if (cnt_ff == LEN_W'(i)) begin
               sav_lex[i*8 +: 8] = source_byte;
            end
         end
         sav_cnt = cnt_ff + LEN_W'(1);
      end else begin
         sav_over = 1'b1;
      end
   end

   // lowest matching reserved slot wins
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = RESERVED_WORDS - 1; i >= 0; i--) begin
         if (!over_ff && reserved_ff[i] != '0 && reserved_ff[i] == lex_ff) begin
            match_any = 1'b1;
            match_idx = IDX_W'(i);
         end
      end
   end

   // start-state step, always from an empty lexeme
   always_comb begin
      st_valid = 1'b0;
      st_state = ST_START;
      st_lex   = '0;
      st_cnt   = '0;
      st_tok   = '0;
      if (end_of_input) begin
         st_valid    = 1'b1;
         st_tok.kind = K_END;
      end else if (is_digit(source_byte)) begin
         st_state = ST_NUM;
         st_lex   = WORD_W'(source_byte);
         st_cnt   = LEN_W'(1);
      end else if (is_letter(source_byte)) begin
         st_state = ST_ID;
         st_lex   = WORD_W'(source_byte);
         st_cnt   = LEN_W'(1);
      end else if (source_byte == CH_COLON) begin
         st_state = ST_ASSIGN;
         st_lex   = WORD_W'(source_byte);
         st_cnt   = LEN_W'(1);
      end else if (is_space(source_byte)) begin
         st_state = ST_START;
      end else if (source_byte == CH_HASH) begin
         st_state = ST_COMMENT;
      end else begin
         st_valid      = 1'b1;
         st_tok.kind   = op_kind(source_byte);
         st_tok.length = LEN_W'(1);
         st_tok.bytes  = WORD_W'(source_byte);
      end
   end

   // next state and lexeme
   always_comb begin
      state_in  = state_ff;
      lex_in    = lex_ff;
      cnt_in    = cnt_ff;
      over_in   = over_ff;
      pre_valid = 1'b0;
      pre_tok   = '0;
      do_start  = 1'b0;
      pre_tok.length = cnt_ff;
      pre_tok.bytes  = lex_ff;
      case (state_ff)
         ST_COMMENT: begin
            if (end_of_input) begin
               pre_valid    = 1'b1;
               pre_tok.kind = K_END;
               state_in     = ST_START;
            end else if (source_byte == CH_HASH) begin
               state_in = ST_START;
            end
         end
         ST_ASSIGN: begin
            pre_valid = 1'b1;
            if (!end_of_input && source_byte == CH_EQ) begin
               pre_tok.kind   = K_ASSIGN;
               pre_tok.length = sav_cnt;
               pre_tok.bytes  = sav_lex;
               state_in       = ST_START;
               lex_in         = '0;
               cnt_in         = '0;
               over_in        = 1'b0;
            end else begin
               pre_tok.kind = K_ERROR;
               do_start     = 1'b1;
            end
         end
         ST_NUM: begin
            if (!end_of_input && is_digit(source_byte)) begin
               lex_in  = sav_lex;
               cnt_in  = sav_cnt;
               over_in = sav_over;
            end else begin
               pre_valid    = 1'b1;
               pre_tok.kind = K_NUMBER;
               do_start     = 1'b1;
            end
         end
         ST_ID: begin
            if (!end_of_input && is_letter(source_byte)) begin
               lex_in  = sav_lex;
               cnt_in  = sav_cnt;
               over_in = sav_over;
            end else begin
               pre_valid     = 1'b1;
               pre_tok.kind  = match_any ? K_RESERVED : K_IDENT;
               pre_tok.index = match_any ? match_idx : '0;
               do_start      = 1'b1;
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase
      if (do_start) begin
         state_in = st_state;
         lex_in   = st_lex;
         cnt_in   = st_cnt;
         over_in  = 1'b0;
      end
   end

   // tokens of this item
   always_comb begin
      tok_count = 2'd0;
      tok0      = '0;
      tok1      = '0;
      if (pre_valid && do_start && st_valid) begin
         tok_count = 2'd2;
         tok0      = pre_tok;
         tok1      = st_tok;
         tok1.last = 1'b1;
      end else if (pre_valid) begin
         tok_count = 2'd1;
         tok0      = pre_tok;
         tok0.last = 1'b1;
      end else if (do_start && st_valid) begin
         tok_count = 2'd1;
         tok0      = st_tok;
         tok0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         lex_ff   <= '0;
         cnt_ff   <= '0;
         over_ff  <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
         lex_ff   <= lex_in;
         cnt_ff   <= cnt_in;
         over_ff  <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORD_REGS; i++) begin
            reserved_ff[i] <= '0;
         end
      end else if (csr_we && csr_index < CSR_INDEX_W'(NUM_WORD_REGS)) begin
         reserved_ff[csr_index[WORD_SEL_W-1:0]] <= csr_wdata;
      end
   end

endmodule

// ----- rtl/core/lts_token_fifo.sv -----
module lts_token_fifo
   import lts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  token_type             push0,
   input  token_type             push1,
   input  logic                  pop,
   output token_type             head,
   output logic                  head_valid,
   output logic                  room,
   output logic [FIFO_LVL_W-1:0] level
);

   token_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_W-1:0] rd_ff, rd_in;
   logic [FIFO_LVL_W-1:0] lvl_ff, lvl_in;

   assign head       = mem_ff[rd_ff];
   assign head_valid = lvl_ff != '0;
   assign room       = lvl_ff <= FIFO_LVL_W'(FIFO_DEPTH - 2);
   assign level      = lvl_ff;

   assign wr_in  = wr_ff + FIFO_PTR_W'(push_count);
   assign rd_in  = rd_ff + FIFO_PTR_W'(pop);
   assign lvl_in = lvl_ff + FIFO_LVL_W'(push_count) - FIFO_LVL_W'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ff + FIFO_PTR_W'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         lvl_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         lvl_ff <= lvl_in;
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import lts_pkg::*;

   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 235;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;

   lts_req_if req ();
   lts_rsp_if rsp ();

   lexical_token_scanner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // scanner prediction state
   scan_state_type    scan_now;
   logic [WORD_W-1:0] lexeme_acc;
   logic [LEN_W-1:0]  lexeme_fill;
   bit                lexeme_dropped;
   logic [WORD_W-1:0] keyword [NUM_WORD_REGS];
   token_type         item_tokens [$];
   token_type         tokens_due [$];

   int error_count    = 0;
   int items_sent     = 0;
   bit tx_gaps_on     = 1'b1;
   bit rx_stalls_on   = 1'b1;
   int rx_hold_cycles = 0;

   logic [7:0] op_chars [9] = '{CH_EQ, CH_LT, CH_PLUS, CH_MINUS, CH_TIMES, CH_OVER,
                                CH_LPAREN, CH_RPAREN, CH_SEMI};

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter_char(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic void keep_byte(logic [7:0] c);
      if (lexeme_fill < MAX_TOKEN_LEN) begin
         lexeme_acc[8*lexeme_fill +: 8] = c;
         lexeme_fill++;
      end else begin
         lexeme_dropped = 1'b1;
      end
   endfunction

   function automatic void emit_token(logic [KIND_W-1:0] kind, int slot);
      token_type t;
      t.kind   = kind;
      t.index  = IDX_W'(slot);
      t.length = lexeme_fill;
      t.bytes  = lexeme_acc;
      t.last   = 1'b0;
      item_tokens.push_back(t);
      lexeme_acc     = '0;
      lexeme_fill    = '0;
      lexeme_dropped = 1'b0;
   endfunction

   function automatic void close_ident();
      bit hit;
      hit = 1'b0;
      if (!lexeme_dropped) begin
         for (int i = 0; i < RESERVED_WORDS; i++) begin
            if (!hit && keyword[i] != '0 && keyword[i] == lexeme_acc) begin
               emit_token(K_RESERVED, i);
               hit = 1'b1;
            end
         end
      end
      if (!hit) emit_token(K_IDENT, 0);
   endfunction

   function automatic void scan_fresh(logic [7:0] c, bit eoi);
      logic [KIND_W-1:0] kind;
      scan_now = ST_START;
      if (eoi) begin
         emit_token(K_END, 0);
      end else if (digit_char(c)) begin
         keep_byte(c);
         scan_now = ST_NUM;
      end else if (letter_char(c)) begin
         keep_byte(c);
         scan_now = ST_ID;
      end else if (c == CH_COLON) begin
         keep_byte(c);
         scan_now = ST_ASSIGN;
      end else if (c == CH_HASH) begin
         scan_now = ST_COMMENT;
      end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_NL)) begin
         case (c)
            CH_EQ:     kind = K_EQ;
            CH_LT:     kind = K_LT;
            CH_PLUS:   kind = K_PLUS;
            CH_MINUS:  kind = K_MINUS;
            CH_TIMES:  kind = K_TIMES;
            CH_OVER:   kind = K_OVER;
            CH_LPAREN: kind = K_LPAREN;
            CH_RPAREN: kind = K_RPAREN;
            CH_SEMI:   kind = K_SEMI;
            default:   kind = K_ERROR;
         endcase
         keep_byte(c);
         emit_token(kind, 0);
      end
   endfunction

   function automatic void predict_item(logic [7:0] c, bit eoi);
      token_type t;
      item_tokens.delete();
      case (scan_now)
         ST_COMMENT: begin
            if (eoi) begin
               scan_now = ST_START;
               emit_token(K_END, 0);
            end else if (c == CH_HASH) begin
               scan_now = ST_START;
            end
         end
         ST_ASSIGN: begin
            if (!eoi && c == CH_EQ) begin
               keep_byte(c);
               scan_now = ST_START;
               emit_token(K_ASSIGN, 0);
            end else begin
               emit_token(K_ERROR, 0);
               scan_fresh(c, eoi);
            end
         end
         ST_NUM: begin
            if (!eoi && digit_char(c)) begin
               keep_byte(c);
            end else begin
               emit_token(K_NUMBER, 0);
               scan_fresh(c, eoi);
            end
         end
         ST_ID: begin
            if (!eoi && letter_char(c)) begin
               keep_byte(c);
            end else begin
               close_ident();
               scan_fresh(c, eoi);
            end
         end
         default: scan_fresh(c, eoi);
      endcase
      foreach (item_tokens[i]) begin
         t = item_tokens[i];
         t.last = (i == item_tokens.size() - 1);
         tokens_due.push_back(t);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [7:0] pick_letter(bit narrow);
      int r;
      if (narrow) return 8'("a" + $urandom_range(0, 2));
      r = $urandom_range(0, 51);
      if (r < 26) return 8'("A" + r);
      return 8'("a" + r - 26);
   endfunction

   function automatic logic [WORD_W-1:0] letter_word(int n, bit narrow);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < n && i < 8; i++) w[8*i +: 8] = pick_letter(narrow);
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] pack_word(string s);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   task automatic send_item(logic [7:0] c, bit eoi);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.source_byte  <= c;
      req.end_of_input <= eoi;
      do @(posedge clock); while (!req.ready);
      predict_item(c, eoi);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // drop valid and wait until every expected token has come back
   task automatic settle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_word(int idx, logic [WORD_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_INDEX_W'(idx);
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx < NUM_WORD_REGS) keyword[idx] = val;
   endtask

   task automatic load_keywords(int phase);
      int r;
      logic [WORD_W-1:0] w;
      for (int i = 0; i < NUM_WORD_REGS; i++) begin
         r = $urandom_range(0, 9);
         if (phase == 0) w = '0;
         else if (phase == 4) w = letter_word($urandom_range(1, 2), 1'b1);
         else if (r == 0) w = '0;
         else if (r == 1) w = '1;
         else if (r == 2) w = {$urandom, $urandom};
         else w = letter_word($urandom_range(1, 8), r < 5);
         write_word(i, w);
      end
      write_word($urandom_range(NUM_WORD_REGS, (1 << CSR_INDEX_W) - 1), {$urandom, $urandom});
   endtask

   task automatic send_fragment();
      int r;
      int n;
      int slot;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         slot = $urandom_range(0, NUM_WORD_REGS - 1);
         if (r < 12 && keyword[slot] != '0) begin
            for (int i = 0; i < 8 && keyword[slot][8*i +: 8] != 8'h00; i++)
               send_item(keyword[slot][8*i +: 8], 1'b0);
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 4);
            repeat (n) send_item(pick_letter(r[0]), 1'b0);
         end
      end else if (r < 37) begin
         n = $urandom_range(1, 10);
         repeat (n) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (r < 45) begin
         send_text(":=");
      end else if (r < 48) begin
         send_item(CH_COLON, 1'b0);
      end else if (r < 64) begin
         send_item(op_chars[$urandom_range(0, 8)], 1'b0);
      end else if (r < 74) begin
         case ($urandom_range(0, 2))
            0:       send_item(CH_SPACE, 1'b0);
            1:       send_item(CH_TAB, 1'b0);
            default: send_item(CH_NL, 1'b0);
         endcase
      end else if (r < 82) begin
         send_item(CH_HASH, 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
         if ($urandom_range(0, 9) != 0) send_item(CH_HASH, 1'b0);
      end else if (r < 92) begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic test_operators();
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      send_text(":=:+-*/()<=;");
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      settle();
   endtask

   task automatic test_reserved_words();
      write_word(0, pack_word("if"));
      write_word(1, pack_word("then"));
      write_word(3, pack_word("then"));
      write_word(7, pack_word("abcdefgh"));
      write_word((1 << CSR_INDEX_W) - 1, '1);
      send_text("then abcdefghi9");
      send_item(8'h00, 1'b1);
      send_text("if#x");
      send_item(8'hFF, 1'b1);
      settle();
   endtask

   task automatic test_backpressure();
      tx_gaps_on     = 1'b0;
      rx_stalls_on   = 1'b1;
      rx_hold_cycles = 200;
      repeat (20) send_text("a+");
      send_text("ab");
      settle();
      send_text("c;");
      settle();
   endtask

   task automatic test_random_scan();
      int goal;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         load_keywords(p);
         tx_gaps_on   = (p != 1);
         rx_stalls_on = (p != 1) && (p != 3);
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) send_fragment();
      end
   endtask

   // result side ready, with random stalls and a forced hold-off
   initial begin : rsp_drive
      int stall_left;
      int r;
      stall_left = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            rx_hold_cycles--;
         end else if (!rx_stalls_on) begin
            rsp.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp.ready <= 1'b1;
            end else begin
               rsp.ready <= 1'b0;
               stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   always @(posedge clock) begin : token_check
      token_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (tokens_due.size() == 0) begin
            $error("unexpected token: kind %0d length %0d bytes %h",
                   rsp.token_kind, rsp.lexeme_length, rsp.lexeme_bytes);
            error_count++;
         end else begin
            want = tokens_due.pop_front();
            if (rsp.token_kind !== want.kind) begin
               $error("token_kind: expected %0d, actual %0d", want.kind, rsp.token_kind);
               error_count++;
            end
            if (rsp.reserved_index !== want.index) begin
               $error("reserved_index: expected %0d, actual %0d", want.index,
                      rsp.reserved_index);
               error_count++;
            end
            if (rsp.lexeme_length !== want.length) begin
               $error("lexeme_length: expected %0d, actual %0d", want.length,
                      rsp.lexeme_length);
               error_count++;
            end
            if (rsp.lexeme_bytes !== want.bytes) begin
               $error("lexeme_bytes: expected %h, actual %h", want.bytes, rsp.lexeme_bytes);
               error_count++;
            end
            if (rsp.last_of_item !== want.last) begin
               $error("last_of_item: expected %0d, actual %0d", want.last, rsp.last_of_item);
               error_count++;
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("lexical_token_scanner_top: mismatch");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req.valid        = 1'b0;
      req.source_byte  = '0;
      req.end_of_input = 1'b0;
      scan_now         = ST_START;
      lexeme_acc       = '0;
      lexeme_fill      = '0;
      lexeme_dropped   = 1'b0;
      foreach (keyword[i]) keyword[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_operators();
      test_reserved_words();
      test_backpressure();
      test_random_scan();

      settle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("lexical_token_scanner_top: match");
      end else begin
         $display("lexical_token_scanner_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/lts_pkg.sv
rtl/core/lts_req_if.sv
rtl/core/lts_rsp_if.sv
rtl/core/lts_scan.sv
rtl/core/lts_token_fifo.sv
rtl/core/lexical_token_scanner_top.sv
tb/tb.sv
